### hw/rtl/dcfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfl_pkg
// Shared types and codes for the descriptor chain free list.
// ----------------------------------------------------------------------------
package dcfl_pkg;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ISSUE,
    ST_WALK,
    ST_DONE
  } state_t;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_COUNT = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

  localparam int unsigned IDX_IN_W   = 16;
  localparam int unsigned COUNT_IN_W = 5;
  localparam int unsigned HEAD_OUT_W = 4;
  localparam int unsigned LEN_OUT_W  = 5;
  localparam int unsigned FREE_OUT_W = 5;

endpackage

### hw/rtl/dcfl_desc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfl_desc_ram
// Descriptor table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dcfl_desc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 5,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/descriptor_chain_free_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_chain_free_list_core
// Linked free list of queue descriptors: alloc, mark and free requests.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    req_type, chain_count, desc_index, chained_bit
//  out      out  out_valid/out_ready  status, head_index, chain_length, free_count
//
//  One request at a time. Errors go from ST_IDLE straight to ST_DONE; mark,
//  alloc and free pass through ST_ISSUE and ST_WALK, where the walk reads one
//  descriptor link per cycle from the descriptor RAM (one read port, registered
//  read data). After reset an init pass writes every RAM entry with in_ready
//  low. A new request is taken while a result waits in the output
//  register; a finished request holds in ST_DONE until that register frees.
// ----------------------------------------------------------------------------
module descriptor_chain_free_list_core #(
  parameter int QUEUE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_chain_count,
  input  logic [15:0] in_desc_index,
  input  logic        in_chained_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_head_index,
  output logic [4:0]  out_chain_length,
  output logic [4:0]  out_free_count
);

  localparam int IW   = $clog2(QUEUE_SIZE);
  localparam int CW   = $clog2(QUEUE_SIZE + 1);
  localparam int CMPW = (CW > dcfl_pkg::COUNT_IN_W) ? CW : dcfl_pkg::COUNT_IN_W;
  localparam int MW   = IW + 1;

  dcfl_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] init_cnt_r, init_cnt_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic          bit_r, bit_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] free_total_r, free_total_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [IW-1:0] res_head_r, res_head_nxt;
  logic [CW-1:0] res_len_r, res_len_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [3:0]    out_head_r, out_head_nxt;
  logic [4:0]    out_len_r, out_len_nxt;
  logic [4:0]    out_free_r, out_free_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  logic [IW-1:0]   rd_link;
  logic            rd_chain;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] total_ext;
  logic            idx_ok;
  logic [CW:0]     sum;

  assign rd_link   = mem_rdata[IW-1:0];
  assign rd_chain  = mem_rdata[IW];
  assign count_ext = CMPW'(in_chain_count);
  assign total_ext = CMPW'(free_total_r);
  assign idx_ok    = {1'b0, in_desc_index} < 17'(QUEUE_SIZE);
  assign sum       = (CW + 1)'(free_total_r) + (CW + 1)'(n_r);

  dcfl_desc_ram #(
    .DEPTH (QUEUE_SIZE),
    .WIDTH (MW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dcfl_pkg::ST_INIT;
      init_cnt_r   <= '0;
      free_head_r  <= '0;
      free_total_r <= CW'(QUEUE_SIZE);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cur_r        <= cur_nxt;
    head_r       <= head_nxt;
    bit_r        <= bit_nxt;
    rem_r        <= rem_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_head_r   <= res_head_nxt;
    res_len_r    <= res_len_nxt;
    out_status_r <= out_status_nxt;
    out_head_r   <= out_head_nxt;
    out_len_r    <= out_len_nxt;
    out_free_r   <= out_free_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    head_nxt       = head_r;
    bit_nxt        = bit_r;
    rem_nxt        = rem_r;
    n_nxt          = n_r;
    free_head_nxt  = free_head_r;
    free_total_nxt = free_total_r;
    res_status_nxt = res_status_r;
    res_head_nxt   = res_head_r;
    res_len_nxt    = res_len_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_head_nxt   = out_head_r;
    out_len_nxt    = out_len_r;
    out_free_nxt   = out_free_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    mem_wdata      = '0;
    mem_raddr      = cur_r;

    unique case (state_r)
      dcfl_pkg::ST_INIT: begin
        // entry i links to i+1, last entry wraps to 0, chained bits clear
        mem_we    = 1'b1;
        mem_waddr = init_cnt_r;
        if (init_cnt_r == IW'(QUEUE_SIZE - 1)) begin
          mem_wdata = '0;
          state_nxt = dcfl_pkg::ST_IDLE;
        end else begin
          mem_wdata = {1'b0, init_cnt_r + 1'b1};
        end
        init_cnt_nxt = init_cnt_r + 1'b1;
      end

      dcfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt         = in_req_type;
          bit_nxt        = in_chained_bit;
          res_status_nxt = dcfl_pkg::STAT_OK;
          res_head_nxt   = '0;
          res_len_nxt    = '0;
          n_nxt          = CW'(1);
          state_nxt      = dcfl_pkg::ST_DONE;
          case (in_req_type)
            dcfl_pkg::REQ_ALLOC: begin
              if (in_chain_count == '0 || count_ext > total_ext) begin
                res_status_nxt = dcfl_pkg::STAT_BAD_COUNT;
              end else begin
                cur_nxt        = free_head_r;
                res_head_nxt   = free_head_r;
                rem_nxt        = CW'(count_ext - 1'b1);
                free_total_nxt = free_total_r - CW'(count_ext);
                state_nxt      = dcfl_pkg::ST_ISSUE;
              end
            end
            dcfl_pkg::REQ_MARK, dcfl_pkg::REQ_FREE: begin
              if (!idx_ok) begin
                res_status_nxt = dcfl_pkg::STAT_BAD_INDEX;
              end else begin
                cur_nxt   = in_desc_index[IW-1:0];
                head_nxt  = in_desc_index[IW-1:0];
                state_nxt = dcfl_pkg::ST_ISSUE;
              end
            end
            default: begin
              res_status_nxt = dcfl_pkg::STAT_BAD_COUNT;
            end
          endcase
        end
      end

      dcfl_pkg::ST_ISSUE: begin
        mem_raddr = cur_r;
        state_nxt = dcfl_pkg::ST_WALK;
      end

      dcfl_pkg::ST_WALK: begin
        // mem_rdata holds the entry at cur_r
        case (op_r)
          dcfl_pkg::REQ_ALLOC: begin
            if (rem_r != '0) begin
              cur_nxt   = rd_link;
              rem_nxt   = rem_r - 1'b1;
              mem_raddr = rd_link;
            end else begin
              mem_we        = 1'b1;
              mem_wdata     = {rd_chain, {IW{1'b0}}};
              free_head_nxt = rd_link;
              state_nxt     = dcfl_pkg::ST_DONE;
            end
          end
          dcfl_pkg::REQ_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = {bit_r, rd_link};
            state_nxt = dcfl_pkg::ST_DONE;
          end
          default: begin
            if (rd_chain && n_r < CW'(QUEUE_SIZE)) begin
              cur_nxt   = rd_link;
              n_nxt     = n_r + 1'b1;
              mem_raddr = rd_link;
            end else begin
              mem_we        = 1'b1;
              mem_wdata     = {rd_chain, free_head_r};
              free_head_nxt = head_r;
              // saturate: a chain freed twice must not push the count past the size
              if (sum > (CW + 1)'(QUEUE_SIZE)) begin
                free_total_nxt = CW'(QUEUE_SIZE);
              end else begin
                free_total_nxt = sum[CW-1:0];
              end
              res_len_nxt = n_r;
              state_nxt   = dcfl_pkg::ST_DONE;
            end
          end
        endcase
      end

      dcfl_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_head_nxt   = dcfl_pkg::HEAD_OUT_W'(res_head_r);
          out_len_nxt    = dcfl_pkg::LEN_OUT_W'(res_len_r);
          out_free_nxt   = dcfl_pkg::FREE_OUT_W'(free_total_r);
          state_nxt      = dcfl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dcfl_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_head_index   = out_head_r;
  assign out_chain_length = out_len_r;
  assign out_free_count   = out_free_r;

`ifndef SYNTHESIS
  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= CW'(QUEUE_SIZE))
    else $error("free count above queue size");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != dcfl_pkg::ST_IDLE))
    else $error("request accepted but controller stayed idle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcfl_pkg::ST_IDLE || state_r == dcfl_pkg::ST_DONE) |-> !mem_we)
    else $error("descriptor RAM written outside a walk");
`endif

endmodule

### test/descriptor_chain_free_list_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_chain_free_list_core_tb
// Drives alloc, mark and free requests into the descriptor free list and
// checks every reply against a cycle-free model of the list kept in the
// bench: count and index errors, endless chains, free-count saturation, then
// random chain traffic with idle gaps and output stalls.
// ----------------------------------------------------------------------------
module descriptor_chain_free_list_core_tb;

  localparam int SLOTS = 16;
  localparam logic [1:0] REQ_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] head;
    logic [4:0] length;
    logic [4:0] remaining;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [4:0]  in_chain_count = '0;
  logic [15:0] in_desc_index = '0;
  logic        in_chained_bit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_head_index;
  logic [4:0]  out_chain_length;
  logic [4:0]  out_free_count;

  // model of the list
  logic [3:0]  desc_next [SLOTS];
  logic        desc_chained [SLOTS];
  logic [3:0]  list_head;
  int unsigned list_free;

  reply_t replies_due[$];
  bit     steady_flow = 1'b0;
  int     errors = 0;
  int     sent_total = 0;
  int     replies_seen = 0;
  int     req_seen [4];

  descriptor_chain_free_list_core #(
    .QUEUE_SIZE(SLOTS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_chain_count   (in_chain_count),
    .in_desc_index    (in_desc_index),
    .in_chained_bit   (in_chained_bit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_head_index   (out_head_index),
    .out_chain_length (out_chain_length),
    .out_free_count   (out_free_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #500000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_error(input string what);
    errors++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // applies one request to the list model and returns the reply it must give
  function automatic reply_t predict_reply(input logic [1:0] req, input logic [4:0] count,
                                           input logic [15:0] idx, input logic chained);
    reply_t      rep;
    logic [3:0]  cur;
    int unsigned steps;
    rep = '0;
    rep.status = dcfl_pkg::STAT_OK;
    case (req)
      dcfl_pkg::REQ_ALLOC: begin
        if (count == 0 || count > list_free) begin
          rep.status = dcfl_pkg::STAT_BAD_COUNT;
        end else begin
          cur = list_head;
          rep.head = cur;
          for (steps = 1; steps < count; steps++) cur = desc_next[cur];
          list_head = desc_next[cur];
          list_free = list_free - count;
          desc_next[cur] = '0;
        end
      end
      dcfl_pkg::REQ_MARK: begin
        if (idx >= SLOTS) rep.status = dcfl_pkg::STAT_BAD_INDEX;
        else desc_chained[idx[3:0]] = chained;
      end
      dcfl_pkg::REQ_FREE: begin
        if (idx >= SLOTS) begin
          rep.status = dcfl_pkg::STAT_BAD_INDEX;
        end else begin
          cur = idx[3:0];
          steps = 1;
          // a looped chain stops after SLOTS descriptors
          while (desc_chained[cur] && steps < SLOTS) begin
            cur = desc_next[cur];
            steps++;
          end
          desc_next[cur] = list_head;
          list_head = idx[3:0];
          list_free = list_free + steps;
          if (list_free > SLOTS) list_free = SLOTS;
          rep.length = 5'(steps);
        end
      end
      default: rep.status = dcfl_pkg::STAT_BAD_COUNT;
    endcase
    rep.remaining = 5'(list_free);
    return rep;
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [4:0] count,
                              input logic [15:0] idx, input logic chained,
                              output reply_t rep);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_chain_count <= count;
    in_desc_index  <= idx;
    in_chained_bit <= chained;
    do @(posedge clk); while (in_ready !== 1'b1);
    rep = predict_reply(req, count, idx, chained);
    replies_due.push_back(rep);
    req_seen[req]++;
    sent_total++;
  endtask

  task automatic wait_all_replies;
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // receiver: random stall before each reply, none during steady stretches
  initial begin : drain_replies
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        report_error("reply with no request pending");
      end else begin
        want = replies_due.pop_front();
        replies_seen++;
        if (out_status !== want.status)
          report_error($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_head_index !== want.head)
          report_error($sformatf("head_index got %0d want %0d", out_head_index, want.head));
        if (out_chain_length !== want.length)
          report_error($sformatf("chain_length got %0d want %0d",
                                 out_chain_length, want.length));
        if (out_free_count !== want.remaining)
          report_error($sformatf("free_count got %0d want %0d",
                                 out_free_count, want.remaining));
      end
    end
  end

  task automatic test_bad_requests;
    reply_t rep;
    send_request(dcfl_pkg::REQ_ALLOC, 5'd0, 16'($urandom), 1'b1, rep);
    send_request(dcfl_pkg::REQ_ALLOC, 5'd17, 16'($urandom), 1'b0, rep);
    send_request(dcfl_pkg::REQ_ALLOC, 5'd31, 16'hFFFF, 1'b1, rep);
    send_request(REQ_UNDEFINED, 5'd1, 16'd0, 1'b1, rep);
    send_request(dcfl_pkg::REQ_MARK, 5'd0, 16'd16, 1'b1, rep);
    send_request(dcfl_pkg::REQ_MARK, 5'd31, 16'hFFFF, 1'b1, rep);
    send_request(dcfl_pkg::REQ_FREE, 5'd0, 16'h8000, 1'b0, rep);
    send_request(dcfl_pkg::REQ_FREE, 5'd3, 16'd16, 1'b1, rep);
    send_request(dcfl_pkg::REQ_MARK, 5'd0, 16'd15, 1'b0, rep);
  endtask

  task automatic test_chain_walks;
    reply_t rep;
    send_request(dcfl_pkg::REQ_ALLOC, 5'd16, 16'd0, 1'b0, rep);  // takes the whole list
    send_request(dcfl_pkg::REQ_ALLOC, 5'd1, 16'd0, 1'b0, rep);   // nothing left
    send_request(dcfl_pkg::REQ_MARK, 5'd0, 16'd0, 1'b1, rep);
    send_request(dcfl_pkg::REQ_MARK, 5'd0, 16'd1, 1'b1, rep);
    send_request(dcfl_pkg::REQ_MARK, 5'd0, 16'd2, 1'b1, rep);
    send_request(dcfl_pkg::REQ_FREE, 5'd0, 16'd0, 1'b0, rep);
    send_request(dcfl_pkg::REQ_FREE, 5'd0, 16'd0, 1'b0, rep);    // same chain again
    send_request(dcfl_pkg::REQ_MARK, 5'd0, 16'd3, 1'b1, rep);    // closes a loop 0..3
    send_request(dcfl_pkg::REQ_FREE, 5'd0, 16'd0, 1'b0, rep);    // walk cut off, saturates
    send_request(dcfl_pkg::REQ_ALLOC, 5'd2, 16'd0, 1'b0, rep);   // flags stay set
    send_request(dcfl_pkg::REQ_MARK, 5'd0, 16'd0, 1'b0, rep);
    send_request(dcfl_pkg::REQ_FREE, 5'd0, 16'd15, 1'b0, rep);
    send_request(dcfl_pkg::REQ_ALLOC, 5'd1, 16'd0, 1'b0, rep);
    wait_all_replies();
  endtask

  // mostly driver-like alloc/mark/free sequences, some random noise requests
  task automatic test_random_traffic;
    reply_t     rep, mark_rep;
    logic [3:0] cur, nxt;
    logic [3:0] held_heads[$];
    int         k, j, pick, goal, roll;
    goal = sent_total + 450;
    while (sent_total < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) steady_flow = !steady_flow;
      if (roll == 99) wait_all_replies();
      if (roll < 80) begin
        if (held_heads.size() == 0 || (list_free > 0 && roll < 45)) begin
          k = (list_free == 0) ? $urandom_range(1, SLOTS) : $urandom_range(1, list_free);
          send_request(dcfl_pkg::REQ_ALLOC, 5'(k), 16'($urandom), 1'($urandom), rep);
          if (rep.status == dcfl_pkg::STAT_OK) begin
            cur = rep.head;
            for (j = 0; j < k; j++) begin
              nxt = desc_next[cur];
              send_request(dcfl_pkg::REQ_MARK, 5'($urandom), 16'(cur), j < k - 1, mark_rep);
              cur = nxt;
            end
            held_heads.push_back(rep.head);
          end
        end else begin
          pick = $urandom_range(0, held_heads.size() - 1);
          send_request(dcfl_pkg::REQ_FREE, 5'($urandom), 16'(held_heads[pick]),
                       1'($urandom), rep);
          held_heads.delete(pick);
        end
      end else begin
        send_request(2'($urandom), 5'($urandom),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, SLOTS - 1)),
                     1'($urandom), rep);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin : run_tests
    int guard;
    for (int i = 0; i < SLOTS; i++) begin
      desc_next[i] = (i + 1 < SLOTS) ? 4'(i + 1) : 4'd0;
      desc_chained[i] = 1'b0;
    end
    list_head = '0;
    list_free = SLOTS;
    for (int i = 0; i < 4; i++) req_seen[i] = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_bad_requests();
    test_chain_walks();
    test_random_traffic();

    in_valid <= 1'b0;
    guard = 0;
    while (replies_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (replies_due.size() != 0)
      report_error($sformatf("%0d replies never arrived", replies_due.size()));

    $display("Sent %0d requests (%0d alloc, %0d mark, %0d free, %0d undefined)",
             sent_total, req_seen[dcfl_pkg::REQ_ALLOC], req_seen[dcfl_pkg::REQ_MARK],
             req_seen[dcfl_pkg::REQ_FREE], req_seen[REQ_UNDEFINED]);
    $display("Checked %0d replies: count and index errors, looped chains, saturation, traffic",
             replies_seen);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
